[rtl/lsca_pkg.sv]
// shared constants for the lfu slot cache admission block
`default_nettype none

package lsca_pkg;

    // default sizes handed to the top level parameters
    localparam int SLOT_COUNT_DEF = 64;
    localparam int ID_BITS_DEF    = 20;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int DYN_BITS      = 7;
    localparam int POS_BITS      = 21;
    localparam int STAMP_BITS    = 32;
    localparam int ACT_BITS      = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 21;

    // seen count at which a node may take a slot
    localparam int ADMIT_MIN = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRAPH_IN_MEMORY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DYNAMIC_SLOTS   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STATIC_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOT_BASE       = 2'd3;

    // result action codes
    localparam logic [ACT_BITS-1:0] ACT_BYPASS  = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_HIT     = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_COUNTED = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_FILL    = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_REPLACE = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_REJECT  = 3'd5;

endpackage

`default_nettype wire

[rtl/lfu_slot_cache_admission.sv]
// top level: configuration, slot scan sequencer, admission decision, result register
//
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  input     | i_in_valid / o_in_ready, node fields     | in
//  result    | o_out_valid / i_out_ready, result fields | out
//  config    | i_cfg_we, i_cfg_index, i_cfg_data        | in
//
// A bypassed item passes only the put step before the next possible transfer; any other item
// also passes the one-slot-a-cycle scan of the slot memory and the last and decide steps.
// After reset the seen count memory is cleared one entry a cycle, during which no item
// is taken; configuration writes are taken at any time.
// One item is in work at a time; the next item is taken while a result waits in
// the output register, and a full output register stalls only the final step.
`default_nettype none

module lfu_slot_cache_admission #(
    parameter int SLOT_COUNT = lsca_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS    = lsca_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = lsca_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lsca_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [lsca_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [ID_BITS-1:0]                  i_node_id,
    input  wire logic                                i_neighbors_present,
    input  wire logic                                i_popular_node,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [lsca_pkg::ACT_BITS-1:0]            o_action,
    output logic [lsca_pkg::POS_BITS-1:0]            o_cache_position,
    output logic                                     o_evicted_valid,
    output logic [ID_BITS-1:0]                       o_evicted_node_id,
    output logic [COUNT_BITS-1:0]                    o_seen_count
);

    localparam int SLOT_IW = $clog2(SLOT_COUNT);
    localparam int SLOT_CW = $clog2(SLOT_COUNT + 1);
    localparam int NW      = (SLOT_CW > lsca_pkg::DYN_BITS) ? SLOT_CW : lsca_pkg::DYN_BITS;
    localparam int IDW     = (ID_BITS > lsca_pkg::POS_BITS) ? ID_BITS : lsca_pkg::POS_BITS;
    localparam int SB      = lsca_pkg::STAMP_BITS;
    localparam int PB      = lsca_pkg::POS_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;

    // configuration registers
    logic                          r_graph_in_memory;
    logic [lsca_pkg::DYN_BITS-1:0] r_dynamic_slots;
    logic [PB-1:0]                 r_static_limit;
    logic [PB-1:0]                 r_slot_base;

    // control state
    logic [2:0]         r_state, n_state;
    logic [SB-1:0]      r_stamp_clock;
    logic [NW-1:0]      r_slots_used;
    logic               r_cmp_live;
    logic               r_out_valid;

    // item and scan state
    logic [ID_BITS-1:0]    r_id;
    logic [SLOT_IW-1:0]    r_scan_idx;
    logic [SLOT_IW-1:0]    r_cmp_idx;
    logic                  r_found;
    logic [SLOT_IW-1:0]    r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_hits;
    logic [SLOT_IW-1:0]    r_vic_idx;
    logic [COUNT_BITS-1:0] r_vic_hits;
    logic [SB-1:0]         r_vic_stamp;
    logic                  r_vic_valid;
    logic [ID_BITS-1:0]    r_vic_node;

    // pending result and output register
    logic [lsca_pkg::ACT_BITS-1:0] r_res_action, r_action;
    logic [PB-1:0]                 r_res_pos, r_pos;
    logic                          r_res_evv, r_evv;
    logic [ID_BITS-1:0]            r_res_evid, r_evid;
    logic [COUNT_BITS-1:0]         r_res_seen, r_seen;

    // memory ports
    logic                  cnt_clearing;
    logic                  cnt_rd_en;
    logic [COUNT_BITS-1:0] cnt_rd_data;
    logic                  cnt_wr_en;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic                  slot_rd_en;
    logic                  slot_rd_valid;
    logic [ID_BITS-1:0]    slot_rd_node;
    logic [COUNT_BITS-1:0] slot_rd_hits;
    logic [SB-1:0]         slot_rd_stamp;
    logic                  slot_wr_en;
    logic [SLOT_IW-1:0]    slot_wr_addr;
    logic [COUNT_BITS-1:0] slot_wr_hits;

    // misc datapath
    logic                          in_xfer;
    logic                          bypass;
    logic [NW-1:0]                 slot_lim;
    logic [COUNT_BITS-1:0]         eff_hits;
    logic [SB-1:0]                 eff_stamp;
    logic                          cmp_hit;
    logic                          cmp_vic;
    logic                          put_go;
    logic [SB-1:0]                 stamp_next;
    logic [COUNT_BITS-1:0]         hit_inc;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic [lsca_pkg::ACT_BITS-1:0] dec_action;
    logic                          dec_evv;
    logic                          dec_used_inc;

    lsca_count_mem #(
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (cnt_clearing),
        .i_rd_en    (cnt_rd_en),
        .i_rd_addr  (i_node_id),
        .o_rd_data  (cnt_rd_data),
        .i_wr_en    (cnt_wr_en),
        .i_wr_addr  (r_id),
        .i_wr_data  (cnt_wr_data)
    );

    lsca_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (slot_rd_en),
        .i_rd_addr  (r_scan_idx),
        .o_rd_valid (slot_rd_valid),
        .o_rd_node  (slot_rd_node),
        .o_rd_hits  (slot_rd_hits),
        .o_rd_stamp (slot_rd_stamp),
        .i_wr_en    (slot_wr_en),
        .i_wr_addr  (slot_wr_addr),
        .i_wr_node  (r_id),
        .i_wr_hits  (slot_wr_hits),
        .i_wr_stamp (stamp_next)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graph_in_memory <= 1'b0;
            r_dynamic_slots   <= '0;
            r_static_limit    <= '0;
            r_slot_base       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsca_pkg::REG_GRAPH_IN_MEMORY: r_graph_in_memory <= i_cfg_data[0];
                lsca_pkg::REG_DYNAMIC_SLOTS: begin
                    r_dynamic_slots <= i_cfg_data[lsca_pkg::DYN_BITS-1:0];
                end
                lsca_pkg::REG_STATIC_LIMIT: r_static_limit <= i_cfg_data;
                lsca_pkg::REG_SLOT_BASE:    r_slot_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // usable slot count, capped at the memory depth
    assign slot_lim = (NW'(r_dynamic_slots) > NW'(SLOT_COUNT)) ? NW'(SLOT_COUNT)
                                                               : NW'(r_dynamic_slots);

    // bypass test on the incoming item
    assign bypass = !r_graph_in_memory || (slot_lim == '0) || !i_neighbors_present
                 || (IDW'(i_node_id) < IDW'(r_static_limit)) || i_popular_node;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cnt_rd_en  = in_xfer && !bypass;
    assign slot_rd_en = (r_state == S_SCAN);
    assign put_go     = !r_out_valid || i_out_ready;

    // scan compare: never-written slots read as empty with zero hits and stamp
    assign eff_hits  = slot_rd_valid ? slot_rd_hits  : '0;
    assign eff_stamp = slot_rd_valid ? slot_rd_stamp : '0;
    assign cmp_hit   = r_cmp_live && !r_found && slot_rd_valid && (slot_rd_node == r_id);
    assign cmp_vic   = r_cmp_live && (NW'(r_cmp_idx) < slot_lim)
                    && ((r_cmp_idx == '0) || (eff_hits < r_vic_hits)
                        || ((eff_hits == r_vic_hits) && (eff_stamp < r_vic_stamp)));

    // saturating increments and next stamp
    assign stamp_next = r_stamp_clock + 1'b1;
    assign hit_inc    = (r_hit_hits == COUNT_MAX) ? r_hit_hits : r_hit_hits + 1'b1;
    assign cnt_inc    = (cnt_rd_data == COUNT_MAX) ? cnt_rd_data : cnt_rd_data + 1'b1;

    // admission decision
    always_comb begin
        dec_action   = lsca_pkg::ACT_COUNTED;
        dec_evv      = 1'b0;
        dec_used_inc = 1'b0;
        slot_wr_addr = r_vic_idx;
        slot_wr_hits = cnt_inc;
        priority if (r_found) begin
            dec_action   = lsca_pkg::ACT_HIT;
            slot_wr_addr = r_hit_idx;
            slot_wr_hits = hit_inc;
        end else if (cnt_inc < COUNT_BITS'(lsca_pkg::ADMIT_MIN)) begin
            dec_action = lsca_pkg::ACT_COUNTED;
        end else if (r_slots_used < slot_lim) begin
            dec_action   = lsca_pkg::ACT_FILL;
            dec_used_inc = 1'b1;
            slot_wr_addr = r_slots_used[SLOT_IW-1:0];
        end else if (cnt_inc < r_vic_hits) begin
            dec_action = lsca_pkg::ACT_REJECT;
        end else begin
            dec_action = lsca_pkg::ACT_REPLACE;
            dec_evv    = r_vic_valid;
        end
    end

    assign cnt_wr_en   = (r_state == S_DECIDE) && !r_found;
    assign cnt_wr_data = cnt_inc;
    assign slot_wr_en  = (r_state == S_DECIDE)
                      && ((dec_action == lsca_pkg::ACT_HIT) || (dec_action == lsca_pkg::ACT_FILL)
                          || (dec_action == lsca_pkg::ACT_REPLACE));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (!cnt_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = bypass ? S_PUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan_idx == SLOT_IW'(SLOT_COUNT - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_PUT;
            S_PUT: begin
                if (put_go) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_stamp_clock <= '0;
            r_slots_used  <= '0;
            r_cmp_live    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_live <= (r_state == S_SCAN);
            if (slot_wr_en) begin
                r_stamp_clock <= stamp_next;
            end
            if ((r_state == S_DECIDE) && dec_used_inc) begin
                r_slots_used <= r_slots_used + 1'b1;
            end
            if ((r_state == S_PUT) && put_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, scan tracking and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_id         <= i_node_id;
            r_scan_idx   <= '0;
            r_found      <= 1'b0;
            r_res_action <= lsca_pkg::ACT_BYPASS;
            r_res_pos    <= '0;
            r_res_evv    <= 1'b0;
            r_res_evid   <= '0;
            r_res_seen   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        r_cmp_idx <= r_scan_idx;
        if (cmp_hit) begin
            r_found    <= 1'b1;
            r_hit_idx  <= r_cmp_idx;
            r_hit_hits <= slot_rd_hits;
        end
        if (cmp_vic) begin
            r_vic_idx   <= r_cmp_idx;
            r_vic_hits  <= eff_hits;
            r_vic_stamp <= eff_stamp;
            r_vic_valid <= slot_rd_valid;
            r_vic_node  <= slot_rd_node;
        end
        if (r_state == S_DECIDE) begin
            r_res_action <= dec_action;
            r_res_pos    <= slot_wr_en ? (r_slot_base + PB'(slot_wr_addr)) : '0;
            r_res_evv    <= dec_evv;
            r_res_evid   <= dec_evv ? r_vic_node : '0;
            r_res_seen   <= r_found ? '0 : cnt_inc;
        end
        if ((r_state == S_PUT) && put_go) begin
            r_action <= r_res_action;
            r_pos    <= r_res_pos;
            r_evv    <= r_res_evv;
            r_evid   <= r_res_evid;
            r_seen   <= r_res_seen;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_action;
    assign o_cache_position  = r_pos;
    assign o_evicted_valid   = r_evv;
    assign o_evicted_node_id = r_evid;
    assign o_seen_count      = r_seen;

endmodule

`default_nettype wire

[rtl/lsca_count_mem.sv]
// per-node seen count memory with a clearing sweep after reset
`default_nettype none

module lsca_count_mem #(
    parameter int ID_BITS    = lsca_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = lsca_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    output logic                       o_clearing,
    input  wire logic                  i_rd_en,
    input  wire logic [ID_BITS-1:0]    i_rd_addr,
    output logic [COUNT_BITS-1:0]      o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [ID_BITS-1:0]    i_wr_addr,
    input  wire logic [COUNT_BITS-1:0] i_wr_data
);

    localparam longint unsigned DEPTH = 64'd1 << ID_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_clearing;
    logic [ID_BITS-1:0]    r_clr_addr;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ID_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_clearing = r_clearing;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

[rtl/lsca_slot_mem.sv]
// dynamic slot memory: node, hit count and stamp per slot, valid bits in flops
`default_nettype none

module lsca_slot_mem #(
    parameter int SLOT_COUNT = lsca_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS    = lsca_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = lsca_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]    i_rd_addr,
    output logic                                  o_rd_valid,
    output logic [ID_BITS-1:0]                    o_rd_node,
    output logic [COUNT_BITS-1:0]                 o_rd_hits,
    output logic [lsca_pkg::STAMP_BITS-1:0]       o_rd_stamp,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]    i_wr_addr,
    input  wire logic [ID_BITS-1:0]               i_wr_node,
    input  wire logic [COUNT_BITS-1:0]            i_wr_hits,
    input  wire logic [lsca_pkg::STAMP_BITS-1:0]  i_wr_stamp
);

    localparam int WORD_BITS = ID_BITS + COUNT_BITS + lsca_pkg::STAMP_BITS;

    logic [WORD_BITS-1:0]  r_mem [SLOT_COUNT];
    logic [WORD_BITS-1:0]  r_rd_word;
    logic                  r_rd_valid;
    logic [SLOT_COUNT-1:0] r_valid;

    // valid bits, cleared by reset, set on every slot write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_node, i_wr_hits, i_wr_stamp};
        end
    end

    // registered read of word and valid bit
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_node  = r_rd_word[WORD_BITS-1 -: ID_BITS];
    assign o_rd_hits  = r_rd_word[lsca_pkg::STAMP_BITS +: COUNT_BITS];
    assign o_rd_stamp = r_rd_word[lsca_pkg::STAMP_BITS-1:0];

endmodule

`default_nettype wire
